// ----- src/usbps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbps_pkg
// Shared widths, codes and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package usbps_pkg;

	// field widths
	localparam int SR_W       = 20;
	localparam int PPS_W      = 13;
	localparam int BPF_W      = 8;
	localparam int FDIV_W     = 5;
	localparam int FB_W       = 26;
	localparam int BYTES_W    = 18;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	// internal widths
	localparam int FRAC_W   = 16;
	localparam int NOM_W    = SR_W + FRAC_W;   // full-width nominal quotient
	localparam int DVD_W    = NOM_W;           // divider dividend
	localparam int DVS_W    = PPS_W;           // divider divisor
	localparam int CNT_W    = 6;
	localparam int ACC_W    = SR_W + 1;        // remainder + sample rate
	localparam int FRAMES_W = ACC_W;
	localparam int PROD_W   = BYTES_W + BPF_W;

	localparam logic [BYTES_W-1:0] BYTES_MAX = '1;
	localparam logic [FB_W-1:0]    OUT26_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAMPLE_RATE        = 2'd0,
		CFG_PACKETS_PER_SECOND = 2'd1,
		CFG_BYTES_PER_FRAME    = 2'd2,
		CFG_FEEDBACK_DIVISOR   = 2'd3
	} cfg_idx_t;

	typedef enum logic [STAT_W-1:0] {
		FB_NONE       = 2'd0,
		FB_IN_WINDOW  = 2'd1,
		FB_OUT_WINDOW = 2'd2
	} fb_status_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic start_nom;
		logic start_scl;
		logic start_rem;
		logic cap_nom;
		logic cap_scl;
		logic cap_win;
		logic cap_rem;
		logic mult;
		logic load_out;
	} usbps_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic fb_nz;
		logic div_done;
		logic in_win;
		logic whole_nz;
		logic out_free;
	} usbps_sts_t;

endpackage

// ----- src/usbps_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbps interfaces
// Valid/ready channels for packet requests, results and register writes.
// ----------------------------------------------------------------------------
interface usbps_req_if;
	import usbps_pkg::*;
	logic            valid;
	logic            ready;
	logic [FB_W-1:0] feedback_value;

	modport source (output valid, output feedback_value, input ready);
	modport sink   (input valid, input feedback_value, output ready);
endinterface

interface usbps_res_if;
	import usbps_pkg::*;
	logic               valid;
	logic               ready;
	logic [BYTES_W-1:0] byte_count;
	logic [STAT_W-1:0]  feedback_status;
	logic [FB_W-1:0]    scaled_feedback;
	logic [FB_W-1:0]    nominal_frames;

	modport source (output valid, output byte_count, output feedback_status,
		output scaled_feedback, output nominal_frames, input ready);
	modport sink   (input valid, input byte_count, input feedback_status,
		input scaled_feedback, input nominal_frames, output ready);
endinterface

interface usbps_cfg_if;
	import usbps_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/usbps_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbps_div
// Restoring divider, one quotient bit per cycle, left-aligned dividend.
// ----------------------------------------------------------------------------
module usbps_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [usbps_pkg::DVD_W-1:0] dividend,   // left-aligned
	input  logic [usbps_pkg::DVS_W-1:0] divisor,
	input  logic [usbps_pkg::CNT_W-1:0] count,      // quotient bits to produce
	output logic                        done,
	output logic [usbps_pkg::DVD_W-1:0] quotient,
	output logic [usbps_pkg::DVS_W-1:0] remainder
);
	import usbps_pkg::*;

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= count;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			// quotient bits shift in from the bottom
			dvd_q <= {dvd_q[DVD_W-2:0], fits};
			rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

// ----- src/usbps_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbps_dp
// Datapath: config registers, accumulators, shared divider, result register.
// ----------------------------------------------------------------------------
module usbps_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  usbps_pkg::usbps_cmd_t            cmd,
	output usbps_pkg::usbps_sts_t            sts,
	// register writes
	input  logic                             cfg_we,
	input  logic [usbps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [usbps_pkg::CFG_DATA_W-1:0] cfg_data,
	// request payload
	input  logic [usbps_pkg::FB_W-1:0]       fb_in,
	// result channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [usbps_pkg::BYTES_W-1:0]    out_bytes,
	output logic [usbps_pkg::STAT_W-1:0]     out_status,
	output logic [usbps_pkg::FB_W-1:0]       out_scaled,
	output logic [usbps_pkg::FB_W-1:0]       out_nominal
);
	import usbps_pkg::*;

	logic [SR_W-1:0]   sample_rate_q;
	logic [PPS_W-1:0]  pps_q;
	logic [BPF_W-1:0]  bpf_q;
	logic [FDIV_W-1:0] fdiv_q;

	logic [FRAC_W-1:0] frac_q;
	logic [PPS_W-1:0]  rate_rem_q;

	logic [FB_W-1:0]     fb_q;
	logic [NOM_W-1:0]    nominal_q;
	logic [NOM_W-1:0]    lo_q;
	logic [NOM_W:0]      hi_q;
	logic [FB_W-1:0]     scaled_q;
	fb_status_t          status_q;
	logic [FRAMES_W-1:0] frames_q;
	logic [PROD_W-1:0]   prod_q;

	logic               out_valid_q;
	logic [BYTES_W-1:0] out_bytes_q;
	logic [STAT_W-1:0]  out_status_q;
	logic [FB_W-1:0]    out_scaled_q;
	logic [FB_W-1:0]    out_nominal_q;

	logic [PPS_W-1:0]  pps_eff;
	logic [FDIV_W-1:0] fdiv_eff;
	logic [ACC_W-1:0]  acc;
	logic [FB_W:0]     sum;
	logic              in_win;

	logic             div_start;
	logic [DVD_W-1:0] div_dividend;
	logic [DVS_W-1:0] div_divisor;
	logic [CNT_W-1:0] div_count;
	logic             div_done;
	logic [DVD_W-1:0] div_quot;
	logic [DVS_W-1:0] div_rem;

	logic [BYTES_W-1:0] frames_sat;
	logic [PROD_W-1:0]  bytes_floor;
	logic [BYTES_W-1:0] bytes_final;
	logic [FB_W-1:0]    nominal_sat;

	// zero divisors behave as one
	assign pps_eff  = (pps_q == '0) ? PPS_W'(1) : pps_q;
	assign fdiv_eff = (fdiv_q == '0) ? FDIV_W'(1) : fdiv_q;

	assign acc    = ACC_W'(rate_rem_q) + ACC_W'(sample_rate_q);
	assign sum    = (FB_W+1)'(frac_q) + (FB_W+1)'(scaled_q);
	assign in_win = (NOM_W'(scaled_q) >= lo_q) && ((NOM_W+1)'(scaled_q) <= hi_q);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= SR_W'(48000);
			pps_q         <= PPS_W'(1000);
			bpf_q         <= BPF_W'(8);
			fdiv_q        <= FDIV_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_SAMPLE_RATE:        sample_rate_q <= cfg_data[SR_W-1:0];
				CFG_PACKETS_PER_SECOND: pps_q         <= cfg_data[PPS_W-1:0];
				CFG_BYTES_PER_FRAME:    bpf_q         <= cfg_data[BPF_W-1:0];
				CFG_FEEDBACK_DIVISOR:   fdiv_q        <= cfg_data[FDIV_W-1:0];
				default: ;
			endcase
		end
	end

	// shared divider
	always_comb begin
		div_dividend = {sample_rate_q, {FRAC_W{1'b0}}};
		div_divisor  = pps_eff;
		div_count    = CNT_W'(NOM_W);
		if (cmd.start_scl) begin
			div_dividend = {fb_q, {(DVD_W-FB_W){1'b0}}};
			div_divisor  = DVS_W'(fdiv_eff);
			div_count    = CNT_W'(FB_W);
		end else if (cmd.start_rem) begin
			div_dividend = {acc, {(DVD_W-ACC_W){1'b0}}};
			div_count    = CNT_W'(ACC_W);
		end
	end

	assign div_start = cmd.start_nom | cmd.start_scl | cmd.start_rem;

	usbps_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.count     (div_count),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// persistent accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q     <= '0;
			rate_rem_q <= '0;
		end else begin
			if (cmd.cap_win && in_win)
				frac_q <= sum[FRAC_W-1:0];
			if (cmd.cap_rem)
				rate_rem_q <= div_rem;
		end
	end

	// per-request working registers
	always_ff @(posedge clk) begin
		lo_q <= nominal_q - (nominal_q >> 3);
		hi_q <= (NOM_W+1)'(nominal_q) + (NOM_W+1)'(nominal_q >> 1);
		if (cmd.accept) begin
			fb_q      <= fb_in;
			status_q  <= FB_NONE;
			scaled_q  <= '0;
			nominal_q <= '0;
		end
		if (cmd.cap_nom)
			nominal_q <= div_quot;
		if (cmd.cap_scl)
			scaled_q <= div_quot[FB_W-1:0];
		if (cmd.cap_win) begin
			status_q <= in_win ? FB_IN_WINDOW : FB_OUT_WINDOW;
			if (in_win)
				frames_q <= FRAMES_W'(sum[FB_W:FRAC_W]);
		end
		if (cmd.cap_rem)
			frames_q <= div_quot[FRAMES_W-1:0];
		if (cmd.mult)
			prod_q <= PROD_W'(frames_sat) * PROD_W'(bpf_q);
	end

	assign frames_sat  = (frames_q > FRAMES_W'(BYTES_MAX)) ? BYTES_MAX
		: frames_q[BYTES_W-1:0];
	// no whole frame still sends one frame
	assign bytes_floor = (prod_q < PROD_W'(bpf_q)) ? PROD_W'(bpf_q) : prod_q;
	assign bytes_final = (bytes_floor > PROD_W'(BYTES_MAX)) ? BYTES_MAX
		: bytes_floor[BYTES_W-1:0];
	assign nominal_sat = (nominal_q > NOM_W'(OUT26_MAX)) ? OUT26_MAX
		: nominal_q[FB_W-1:0];

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_bytes_q   <= bytes_final;
			out_status_q  <= status_q;
			out_scaled_q  <= scaled_q;
			out_nominal_q <= nominal_sat;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_bytes   = out_bytes_q;
	assign out_status  = out_status_q;
	assign out_scaled  = out_scaled_q;
	assign out_nominal = out_nominal_q;

	assign sts.fb_nz    = fb_in != '0;
	assign sts.div_done = div_done;
	assign sts.in_win   = in_win;
	assign sts.whole_nz = sum[FB_W:FRAC_W] != '0;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

// ----- src/usbps_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbps_ctrl
// Sequencer for one packet request: divisions, window check, sizing.
// ----------------------------------------------------------------------------
module usbps_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  usbps_pkg::usbps_sts_t sts,
	output usbps_pkg::usbps_cmd_t cmd
);
	import usbps_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_NOM  = 7'b0000010,   // nominal rate division
		S_SCL  = 7'b0000100,   // feedback / divisor
		S_WIN  = 7'b0001000,   // window test, fraction accumulate
		S_REM  = 7'b0010000,   // remainder accumulator division
		S_MUL  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.fb_nz) begin
						cmd.start_nom = 1'b1;
						state_d       = S_NOM;
					end else begin
						cmd.start_rem = 1'b1;
						state_d       = S_REM;
					end
				end
			end
			S_NOM: begin
				if (sts.div_done) begin
					cmd.cap_nom   = 1'b1;
					cmd.start_scl = 1'b1;
					state_d       = S_SCL;
				end
			end
			S_SCL: begin
				if (sts.div_done) begin
					cmd.cap_scl = 1'b1;
					state_d     = S_WIN;
				end
			end
			S_WIN: begin
				cmd.cap_win = 1'b1;
				if (sts.in_win && sts.whole_nz) begin
					state_d = S_MUL;
				end else begin
					cmd.start_rem = 1'b1;
					state_d       = S_REM;
				end
			end
			S_REM: begin
				if (sts.div_done) begin
					cmd.cap_rem = 1'b1;
					state_d     = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mult = 1'b1;
				state_d  = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_ready = state_q == S_IDLE;

endmodule

// ----- src/usb_audio_packet_size_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_audio_packet_size_scheduler
// Sizes isochronous audio packets from Q16.16 feedback or the nominal rate.
// ----------------------------------------------------------------------------
// Usage:
//  - feedback: one request per USB packet, carrying the raw Q16.16 feedback
//    value (zero when the host gave none). Taken when valid and ready are high.
//  - result: one result per request: byte count, feedback status, scaled
//    feedback and nominal rate. Held in an output register until taken.
//  - cfg: register writes (index 0 sample rate, 1 packets per second,
//    2 bytes per frame, 3 feedback divisor). Always ready; write only while
//    no request is in flight.
//  - Divisions: one bit-serial divider does every division. A request
//    without feedback needs only the 21-bit remainder division; with
//    feedback the 36-bit nominal and 26-bit feedback divisions, plus the
//    remainder division out of window or with no whole frame. One request
//    is worked at a time; the next is not taken until this one finishes.
//  - A result that waits for the receiver does not block the next request;
//    only a second finished result waits until the first is taken.
//  - Reset restores the default registers (48000, 1000, 8, 1) and clears the
//    fraction and remainder accumulators.
// ----------------------------------------------------------------------------
module usb_audio_packet_size_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	usbps_req_if.sink   feedback,
	usbps_res_if.source result,
	usbps_cfg_if.sink   cfg
);
	import usbps_pkg::*;

	usbps_cmd_t cmd;
	usbps_sts_t sts;
	logic       req_fire;
	logic       cfg_we;

	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;
	assign req_fire  = feedback.valid && feedback.ready;

	usbps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (feedback.valid),
		.in_ready (feedback.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// request payload sampled on accept inside the datapath
	usbps_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.fb_in       (req_fire ? feedback.feedback_value : '0),
		.out_valid   (result.valid),
		.out_ready   (result.ready),
		.out_bytes   (result.byte_count),
		.out_status  (result.feedback_status),
		.out_scaled  (result.scaled_feedback),
		.out_nominal (result.nominal_frames)
	);

endmodule

// ----- src/usbps_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbps_checker
// Port-level checks on request and result channels.
// ----------------------------------------------------------------------------
module usbps_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [usbps_pkg::BYTES_W-1:0]    byte_count,
	input logic [usbps_pkg::STAT_W-1:0]     feedback_status,
	input logic [usbps_pkg::FB_W-1:0]       scaled_feedback,
	input logic [usbps_pkg::FB_W-1:0]       nominal_frames
);
	import usbps_pkg::*;

	// one request at a time: ready drops after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while one in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> feedback_status != 2'd3)
		else $error("illegal feedback status");

	a_no_fb_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && feedback_status == FB_NONE |->
			scaled_feedback == '0 && nominal_frames == '0)
		else $error("no-feedback result carries feedback fields");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_count)
			&& $stable(feedback_status) && $stable(scaled_feedback)
			&& $stable(nominal_frames))
		else $error("stalled result changed");

endmodule

bind usb_audio_packet_size_scheduler usbps_checker u_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (feedback.valid),
	.in_ready        (feedback.ready),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.byte_count      (result.byte_count),
	.feedback_status (result.feedback_status),
	.scaled_feedback (result.scaled_feedback),
	.nominal_frames  (result.nominal_frames)
);

// ----- tb/usbps_packet_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usbps_packet_checker
// Watches the request, result and register channels, predicts every packet
// size and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module usbps_packet_checker (
	input  logic clk,
	input  logic arst_n,
	usbps_req_if req,
	usbps_res_if res,
	usbps_cfg_if cfg,
	output int   n_errors,
	output int   pending,
	output int   n_checked,
	output int   n_none,
	output int   n_in_win,
	output int   n_out_win
);
	import usbps_pkg::*;

	typedef struct {
		logic [BYTES_W-1:0] bytes;
		fb_status_t         status;
		logic [FB_W-1:0]    scaled;
		logic [FB_W-1:0]    nominal;
	} packet_result_t;

	// register copies
	logic [SR_W-1:0]   rate_q;
	logic [PPS_W-1:0]  pps_q;
	logic [BPF_W-1:0]  bpf_q;
	logic [FDIV_W-1:0] div_q;
	// accumulators
	logic [FRAC_W-1:0] frac_q;
	logic [PPS_W-1:0]  rem_q;

	packet_result_t expected_packets[$];
	int             err_cnt;
	int             checked;
	int             status_cnt[3];

	assign n_errors  = err_cnt;
	assign n_none    = status_cnt[FB_NONE];
	assign n_in_win  = status_cnt[FB_IN_WINDOW];
	assign n_out_win = status_cnt[FB_OUT_WINDOW];

	task automatic report_mismatch(input string msg);
		err_cnt++;
		$display("%t ERROR %s", $time, msg);
	endtask

	// Sizes one packet and advances the fraction / remainder accumulators.
	function automatic packet_result_t size_packet(input logic [FB_W-1:0] fb);
		packet_result_t   r;
		longint unsigned  pps, dv, nom, lo, hi, scl, sum, acc, frames, b;
		bit               from_rate;
		pps       = (pps_q == '0) ? 1 : pps_q;
		r.status  = FB_NONE;
		r.scaled  = '0;
		r.nominal = '0;
		from_rate = 1'b1;
		frames    = 0;
		if (fb != '0) begin
			dv  = (div_q == '0) ? 1 : div_q;
			nom = rate_q;
			nom = (nom << FRAC_W) / pps;
			lo  = nom - nom / 8;
			hi  = nom + nom / 2;
			scl = fb / dv;
			r.scaled  = scl[FB_W-1:0];
			// window test uses the full nominal, the report saturates
			r.nominal = (nom > OUT26_MAX) ? OUT26_MAX : nom[FB_W-1:0];
			if (scl >= lo && scl <= hi) begin
				r.status  = FB_IN_WINDOW;
				sum       = frac_q + scl;
				frames    = sum >> FRAC_W;
				frac_q    = sum[FRAC_W-1:0];
				from_rate = (frames == 0);
			end else begin
				r.status = FB_OUT_WINDOW;
			end
		end
		if (from_rate) begin
			acc    = rem_q + rate_q;
			frames = acc / pps;
			rem_q  = PPS_W'(acc % pps);
		end
		if (frames > BYTES_MAX)
			frames = BYTES_MAX;
		b = frames * bpf_q;
		if (b < bpf_q)
			b = bpf_q;
		if (b > BYTES_MAX)
			b = BYTES_MAX;
		r.bytes = b[BYTES_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		packet_result_t want;
		if (!arst_n) begin
			rate_q  = 20'd48000;
			pps_q   = 13'd1000;
			bpf_q   = 8'd8;
			div_q   = 5'd1;
			frac_q  = '0;
			rem_q   = '0;
			err_cnt = 0;
			checked = 0;
			foreach (status_cnt[i])
				status_cnt[i] = 0;
			expected_packets.delete();
			pending   <= 0;
			n_checked <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg_idx_t'(cfg.index))
					CFG_SAMPLE_RATE:        rate_q = cfg.data[SR_W-1:0];
					CFG_PACKETS_PER_SECOND: pps_q  = cfg.data[PPS_W-1:0];
					CFG_BYTES_PER_FRAME:    bpf_q  = cfg.data[BPF_W-1:0];
					CFG_FEEDBACK_DIVISOR:   div_q  = cfg.data[FDIV_W-1:0];
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				if (expected_packets.size() == 0) begin
					report_mismatch($sformatf("result with no request waiting (bytes %0d)",
						res.byte_count));
				end else begin
					want = expected_packets.pop_front();
					status_cnt[want.status]++;
					if (res.byte_count !== want.bytes)
						report_mismatch($sformatf("packet %0d: byte_count %0d, expected %0d",
							checked, res.byte_count, want.bytes));
					if (res.feedback_status !== want.status)
						report_mismatch($sformatf("packet %0d: feedback_status %0d, expected %0d",
							checked, res.feedback_status, want.status));
					if (res.scaled_feedback !== want.scaled)
						report_mismatch($sformatf("packet %0d: scaled_feedback %0d, expected %0d",
							checked, res.scaled_feedback, want.scaled));
					if (res.nominal_frames !== want.nominal)
						report_mismatch($sformatf("packet %0d: nominal_frames %0d, expected %0d",
							checked, res.nominal_frames, want.nominal));
				end
				checked++;
			end
			if (req.valid && req.ready)
				expected_packets.push_back(size_packet(req.feedback_value));
			pending   <= expected_packets.size();
			n_checked <= checked;
		end
	end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives packet requests and register writes into the packet size scheduler,
// stalls both channels at random and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module tb_top;
	import usbps_pkg::*;

	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 115;
	// longest quiet stretch: receiver hold-off plus a slow request or two
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 600;
	localparam int HOLD_AFTER  = 300;
	// drain time at the end, once no predicted packet is outstanding
	localparam int SETTLE      = 200;

	logic clk;
	logic arst_n;

	usbps_req_if req ();
	usbps_res_if res ();
	usbps_cfg_if cfg ();

	int n_errors, pending, n_checked, n_none, n_in_win, n_out_win;

	// register values currently programmed, used only to aim the feedback
	logic [SR_W-1:0]   cur_sr;
	logic [PPS_W-1:0]  cur_pps;
	logic [FDIV_W-1:0] cur_div;

	bit sender_gaps;
	int n_settings;
	int idle_cycles = 0;

	usb_audio_packet_size_scheduler u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.feedback (req),
		.result   (res),
		.cfg      (cfg)
	);

	usbps_packet_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.cfg       (cfg),
		.n_errors  (n_errors),
		.pending   (pending),
		.n_checked (n_checked),
		.n_none    (n_none),
		.n_in_win  (n_in_win),
		.n_out_win (n_out_win)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// One request: optional gap with valid low, then hold valid until taken.
	// valid stays high afterwards so back-to-back requests need no re-raise.
	task automatic send_request(input logic [FB_W-1:0] value);
		int gap;
		gap = sender_gaps ? $urandom_range(0, 10) : 0;
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid          <= 1'b1;
		req.feedback_value <= value;
		do @(posedge clk); while (!req.ready);
	endtask

	// Stop offering and wait until every predicted packet has been taken.
	task automatic wait_idle();
		req.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// Registers only change with nothing in flight.
	task automatic set_config(input logic [SR_W-1:0] sr, input logic [PPS_W-1:0] pps,
		input logic [BPF_W-1:0] bpf, input logic [FDIV_W-1:0] dv);
		wait_idle();
		write_reg(CFG_SAMPLE_RATE, sr);
		write_reg(CFG_PACKETS_PER_SECOND, pps);
		write_reg(CFG_BYTES_PER_FRAME, bpf);
		write_reg(CFG_FEEDBACK_DIVISOR, dv);
		cfg.valid <= 1'b0;
		cur_sr  = sr;
		cur_pps = pps;
		cur_div = dv;
		n_settings++;
	endtask

	// Feedback mix: no feedback, raw noise, tiny values, the window edges and,
	// mostly, values that land inside the window for the current setting so
	// the fraction accumulator gets real work.
	function automatic logic [FB_W-1:0] pick_feedback();
		longint unsigned nom, lo, hi, dv, scl, fb;
		int unsigned     kind;
		kind = $urandom_range(0, 19);
		dv   = (cur_div == '0) ? 1 : cur_div;
		nom  = cur_sr;
		nom  = (nom << FRAC_W) / ((cur_pps == '0) ? 1 : cur_pps);
		lo   = nom - nom / 8;
		hi   = nom + nom / 2;
		if (kind < 3)
			return '0;
		if (kind < 5)
			return FB_W'($urandom());
		if (kind == 5)
			return FB_W'($urandom_range(1, 1023));
		case (kind)
			6:       scl = lo - 1;
			7:       scl = lo;
			8:       scl = hi;
			9:       scl = hi + 1;
			default: scl = lo + ({$urandom(), $urandom()} % (hi - lo + 1));
		endcase
		fb = scl * dv + 64'($urandom_range(0, int'(dv) - 1));
		// window out of reach for this setting: fall back to noise
		if (fb == 0 || fb > OUT26_MAX)
			return FB_W'($urandom());
		return fb[FB_W-1:0];
	endfunction

	// Result side: random stalls, quiet stretches with ready held high, and
	// one long hold-off so the output register and the finished result back
	// up and the request channel has to stall.
	initial begin : result_sink
		int gap;
		bit held;
		held = 1'b0;
		res.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && n_checked >= HOLD_AFTER) begin
				gap  = HOLD_CYCLES;
				held = 1'b1;
			end else if (((n_checked / 100) % 3) == 2) begin
				gap = 0;
			end else begin
				gap = $urandom_range(0, 10);
			end
			if (gap != 0) begin
				res.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
		end
	end

	// Watchdog: no transfer on any channel for too long ends the run.
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%t watchdog: no transfer for %0d cycles, %0d results outstanding",
				$time, idle_cycles, pending);
			$display("usb_audio_packet_size_scheduler test failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [SR_W-1:0]   sr;
		logic [PPS_W-1:0]  pps;
		logic [BPF_W-1:0]  bpf;
		logic [FDIV_W-1:0] dv;
		arst_n             <= 1'b0;
		req.valid          <= 1'b0;
		req.feedback_value <= '0;
		cfg.valid          <= 1'b0;
		cfg.index          <= CFG_SAMPLE_RATE;
		cfg.data           <= '0;
		cur_sr      = 20'd48000;
		cur_pps     = 13'd1000;
		cur_div     = 5'd1;
		n_settings  = 1;
		sender_gaps = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed: reset defaults, 48 kHz at 1 kHz packets ---
		// nominal 3145728, window 2752512 .. 4718592
		send_request('0);
		send_request(26'd1);
		send_request(26'h3ffffff);
		send_request(26'd3145728);
		send_request(26'd2752512);
		send_request(26'd2752511);
		send_request(26'd4718592);
		send_request(26'd4718593);
		send_request('0);

		// one frame per packet: first in-window step gives no whole frame and
		// falls back to the rate path, the second carries over
		set_config(20'd8000, 13'd8000, 8'd1, 5'd1);
		send_request(26'd57344);
		send_request(26'd57344);

		// zero divisor, zero packet rate, zero frame size, nominal overflow
		set_config(20'hfffff, 13'd0, 8'd0, 5'd0);
		send_request('0);
		send_request(26'h3ffffff);

		// packet byte count clamps at the top
		set_config(20'hfffff, 13'd0, 8'd255, 5'd0);
		send_request(26'h3ffffff);

		// leave a large remainder, then shrink the packet rate below it
		set_config(20'd8190, 13'd8191, 8'd3, 5'd31);
		send_request('0);
		set_config(20'd8190, 13'd1000, 8'd3, 5'd31);
		send_request('0);
		send_request(26'd1234567);

		// --- random phases, one register setting each ---
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin sr = 20'd8000;   pps = 13'd1000; bpf = 8'd1;   dv = 5'd1;  end
				1: begin sr = 20'hfffff;  pps = 13'h1fff; bpf = 8'hff;  dv = 5'h1f; end
				// rate drops after the widest setting: stale remainder
				2: begin sr = SR_W'($urandom_range(8000, 768000)); pps = 13'd1000;
					bpf = BPF_W'($urandom_range(1, 128)); dv = 5'd1; end
				3: begin sr = '0;         pps = '0;       bpf = '0;     dv = '0;    end
				4: begin sr = 20'd768000; pps = 13'd8000; bpf = 8'd128; dv = 5'd16; end
				default: begin
					sr  = ($urandom_range(0, 7) == 0) ? SR_W'($urandom())
						: SR_W'($urandom_range(8000, 768000));
					if ($urandom_range(0, 7) == 0)
						pps = PPS_W'($urandom());
					else if ($urandom_range(0, 1))
						pps = $urandom_range(0, 1) ? 13'd1000 : 13'd8000;
					else
						pps = PPS_W'($urandom_range(1000, 8000));
					bpf = ($urandom_range(0, 7) == 0) ? BPF_W'($urandom())
						: BPF_W'($urandom_range(1, 128));
					dv  = ($urandom_range(0, 7) == 0) ? FDIV_W'($urandom())
						: FDIV_W'($urandom_range(1, 4));
				end
			endcase
			set_config(sr, pps, bpf, dv);
			// every third phase runs the sender flat out
			sender_gaps = (p % 3) != 1;
			repeat (PHASE_ITEMS)
				send_request(pick_feedback());
		end

		wait_idle();
		repeat (SETTLE) @(posedge clk);

		$display("Checked %0d packets over %0d register settings:", n_checked, n_settings);
		$display("  %0d without feedback, %0d in window, %0d out of window, %0d errors",
			n_none, n_in_win, n_out_win, n_errors);
		if (n_errors == 0 && pending == 0)
			$display("usb_audio_packet_size_scheduler test passed");
		else
			$display("usb_audio_packet_size_scheduler test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/usbps_pkg.sv
src/usbps_if.sv
src/usbps_div.sv
src/usbps_dp.sv
src/usbps_ctrl.sv
src/usb_audio_packet_size_scheduler.sv
src/usbps_checker.sv
tb/usbps_packet_checker.sv
tb/tb_top.sv
